/* rtl/core/cbs_pkg.sv */
// Shared types, field widths and register codes for the ring shader core.
package cbs_pkg;

	localparam int COORD_W    = 11;
	localparam int VAL_W      = 8;
	localparam int TIDX_W     = 12;
	localparam int RADIUS_W   = 12;
	localparam int BAND_W     = 5;
	localparam int CFG_DATA_W = 12;

	localparam logic [RADIUS_W-1:0] RADIUS_RST = 12'd64;
	localparam logic [BAND_W-1:0]   BAND_RST   = 5'd16;

	typedef enum logic [1:0] {
		CFG_CENTER_COL = 2'd0,
		CFG_CENTER_ROW = 2'd1,
		CFG_RADIUS     = 2'd2,
		CFG_BAND_WIDTH = 2'd3
	} cfg_idx_t;

	typedef enum logic {
		ACT_LOAD  = 1'b0,
		ACT_SHADE = 1'b1
	} action_t;

	// item bookkeeping carried down the pipe; val holds table data for a load
	typedef struct packed {
		logic              shade;
		logic [VAL_W-1:0]  val;
		logic [TIDX_W-1:0] tidx;
	} meta_t;

	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic             in_band;
	} res_t;

endpackage

/* rtl/core/cbs_ifs.sv */
// Valid/ready channel interfaces for pixel input, result output and configuration.
interface cbs_pix_if;
	logic                          valid;
	logic                          ready;
	logic                          action;
	logic [cbs_pkg::COORD_W-1:0]   pixel_col;
	logic [cbs_pkg::COORD_W-1:0]   pixel_row;
	logic [cbs_pkg::VAL_W-1:0]     pixel_value;
	logic [cbs_pkg::TIDX_W-1:0]    table_index;
	logic [cbs_pkg::VAL_W-1:0]     table_data;

	modport source (output valid, action, pixel_col, pixel_row, pixel_value, table_index,
		table_data, input ready);
	modport sink (input valid, action, pixel_col, pixel_row, pixel_value, table_index,
		table_data, output ready);
endinterface

interface cbs_res_if;
	logic                      valid;
	logic                      ready;
	logic [cbs_pkg::VAL_W-1:0] out_value;
	logic                      in_band;

	modport source (output valid, out_value, in_band, input ready);
	modport sink (input valid, out_value, in_band, output ready);
endinterface

interface cbs_cfg_if;
	logic                           valid;
	logic                           ready;
	cbs_pkg::cfg_idx_t              index;
	logic [cbs_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* rtl/core/cbs_shade_mem.sv */
// Shade table: single write port, one registered read port.
module cbs_shade_mem #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [AW-1:0]             waddr,
	input  logic [cbs_pkg::VAL_W-1:0] wdata,
	input  logic                      re,
	input  logic [AW-1:0]             raddr,
	output logic [cbs_pkg::VAL_W-1:0] rdata
);
	import cbs_pkg::*;

	logic [VAL_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* rtl/core/circular_band_shade_lut_core.sv */
// Ring shader core: pipelined distance root, ring test and shade table lookup.
// Throughput: one item per cycle while the result queue has a free slot; the root takes one pipeline
// stage per result bit. The table is written and read at the same stage, so item order holds with no
// forwarding. Reset clears pipeline valids, the result queue and the centre; radius and band take
// their reset values. Table contents stay undefined after reset.
module circular_band_shade_lut_core #(
	parameter int COORD_BITS  = 11,
	parameter int MAX_BAND    = 16,
	parameter int TABLE_DEPTH = 4096
) (
	input  logic      clk,
	input  logic      arst_n,
	cbs_pix_if.sink   pix,
	cbs_res_if.source res,
	cbs_cfg_if.sink   cfg
);
	import cbs_pkg::*;

	localparam int CW  = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
	localparam int RB  = CW + 1;
	localparam int XW  = 2 * RB;
	localparam int RMW = RB + 2;
	localparam int BW  = $clog2(MAX_BAND + 1);
	localparam int PW  = VAL_W + BW;
	localparam int AW  = PW + 1;
	localparam int TAW = $clog2(TABLE_DEPTH);
	localparam int SW  = RADIUS_W + 2;

	// configuration registers
	logic [COORD_W-1:0]  center_col_q;
	logic [COORD_W-1:0]  center_row_q;
	logic [RADIUS_W-1:0] radius_q;
	logic [BAND_W-1:0]   band_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_col_q <= '0;
			center_row_q <= '0;
			radius_q     <= RADIUS_RST;
			band_q       <= BAND_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				CFG_CENTER_COL: center_col_q <= cfg.data[COORD_W-1:0];
				CFG_CENTER_ROW: center_row_q <= cfg.data[COORD_W-1:0];
				CFG_RADIUS:     radius_q     <= cfg.data[RADIUS_W-1:0];
				CFG_BAND_WIDTH: band_q       <= cfg.data[BAND_W-1:0];
				default: ;
			endcase
		end
	end

	// whole pipe advances while the result queue has a free slot
	logic [1:0] cnt_q;
	logic       adv;

	assign adv       = (cnt_q != 2'd2);
	assign pix.ready = adv;

	// stage 1: absolute offsets from the centre
	logic [CW-1:0] col, row, ccol, crow, dcol, drow;
	meta_t         meta_in;

	assign col  = pix.pixel_col[CW-1:0];
	assign row  = pix.pixel_row[CW-1:0];
	assign ccol = center_col_q[CW-1:0];
	assign crow = center_row_q[CW-1:0];
	assign dcol = (col >= ccol) ? col - ccol : ccol - col;
	assign drow = (row >= crow) ? row - crow : crow - row;

	assign meta_in.shade = (pix.action == ACT_SHADE);
	assign meta_in.val   = (pix.action == ACT_SHADE) ? pix.pixel_value : pix.table_data;
	assign meta_in.tidx  = pix.table_index;

	logic          vld_s1;
	meta_t         meta_s1;
	logic [CW-1:0] dcol_s1, drow_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= pix.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s1 <= meta_in;
			dcol_s1 <= dcol;
			drow_s1 <= drow;
		end
	end

	// stage 2: squares
	logic            vld_s2;
	meta_t           meta_s2;
	logic [2*CW-1:0] sqc_s2, sqr_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s2 <= meta_s1;
			sqc_s2  <= (2*CW)'(dcol_s1) * (2*CW)'(dcol_s1);
			sqr_s2  <= (2*CW)'(drow_s1) * (2*CW)'(drow_s1);
		end
	end

	// stage 3: squared distance
	logic          vld_s3;
	meta_t         meta_s3;
	logic [XW-1:0] x_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s3 <= meta_s2;
			x_s3    <= XW'(sqc_s2) + XW'(sqr_s2);
		end
	end

	// stage 4: restoring square root, one result bit per stage
	logic           vld_s4  [RB];
	meta_t          meta_s4 [RB];
	logic [XW-1:0]  x_s4    [RB];
	logic [RMW-1:0] rem_s4  [RB];
	logic [RB-1:0]  root_s4 [RB];

	for (genvar k = 0; k < RB; k++) begin : g_sqrt
		logic           v_in;
		meta_t          m_in;
		logic [XW-1:0]  x_in;
		logic [RMW-1:0] r_in, pre, trial, diff;
		logic [RB-1:0]  q_in;
		logic           take;

		if (k == 0) begin : g_first
			assign v_in = vld_s3;
			assign m_in = meta_s3;
			assign x_in = x_s3;
			assign r_in = '0;
			assign q_in = '0;
		end else begin : g_next
			assign v_in = vld_s4[k-1];
			assign m_in = meta_s4[k-1];
			assign x_in = x_s4[k-1];
			assign r_in = rem_s4[k-1];
			assign q_in = root_s4[k-1];
		end

		assign pre   = {r_in[RB-1:0], x_in[2*(RB-1-k)+1 -: 2]};
		assign trial = {q_in, 2'b01};
		assign take  = (pre >= trial);
		assign diff  = pre - trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s4[k] <= 1'b0;
			end else if (adv) begin
				vld_s4[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				meta_s4[k] <= m_in;
				x_s4[k]    <= x_in;
				rem_s4[k]  <= take ? diff : pre;
				root_s4[k] <= {q_in[RB-2:0], take};
			end
		end
	end

	// stage 5: ring test, level offset and row base of the table
	logic [BW-1:0] band_sat;
	logic [SW-1:0] d_e, rad_e, bnd_e, sum_e;
	logic          ring;

	assign band_sat = (int'(band_q) > MAX_BAND) ? BW'(MAX_BAND) : BW'(band_q);
	assign d_e      = SW'(root_s4[RB-1]);
	assign rad_e    = SW'(radius_q);
	assign bnd_e    = SW'(band_sat);
	assign sum_e    = d_e + bnd_e;
	assign ring     = (band_sat != '0) && (d_e < rad_e) && (sum_e >= rad_e);

	logic          vld_s5, ring_s5;
	meta_t         meta_s5;
	logic [BW-1:0] off_s5;
	logic [PW-1:0] prod_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s5 <= vld_s4[RB-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s5 <= meta_s4[RB-1];
			ring_s5 <= ring;
			off_s5  <= BW'(sum_e - rad_e);
			prod_s5 <= PW'(meta_s4[RB-1].val) * PW'(band_sat);
		end
	end

	// stage 6: lookup address and range check
	logic [AW-1:0] addr_full;

	assign addr_full = AW'(prod_s5) + AW'(off_s5);

	logic           vld_s6, hit_s6;
	meta_t          meta_s6;
	logic [TAW-1:0] raddr_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (adv) begin
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s6  <= meta_s5;
			hit_s6   <= ring_s5 && (int'(addr_full) < TABLE_DEPTH);
			raddr_s6 <= TAW'(addr_full);
		end
	end

	// stage 7: table access; loads write here, pixels read here
	logic             tbl_we;
	logic [VAL_W-1:0] rd_data;

	assign tbl_we = adv && vld_s6 && !meta_s6.shade && (int'(meta_s6.tidx) < TABLE_DEPTH);

	cbs_shade_mem #(
		.DEPTH (TABLE_DEPTH),
		.AW    (TAW)
	) u_mem (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (TAW'(meta_s6.tidx)),
		.wdata (meta_s6.val),
		.re    (adv),
		.raddr (raddr_s6),
		.rdata (rd_data)
	);

	logic             vld_s7, hit_s7;
	logic [VAL_W-1:0] val_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else if (adv) begin
			vld_s7 <= vld_s6 && meta_s6.shade;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hit_s7 <= hit_s6;
			val_s7 <= meta_s6.val;
		end
	end

	// two-entry result queue with read and write pointers
	res_t res_q [2];
	res_t entry;
	logic wp_q, rp_q;
	logic push, pop;

	assign entry.value   = hit_s7 ? rd_data : val_s7;
	assign entry.in_band = hit_s7;
	assign push          = adv && vld_s7;
	assign pop           = res.valid && res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
		end else begin
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			res_q[wp_q] <= entry;
		end
	end

	assign res.valid     = (cnt_q != 2'd0);
	assign res.out_value = res_q[rp_q].value;
	assign res.in_band   = res_q[rp_q].in_band;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'd2)
		else $error("result queue count out of range");

	a_full_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd2 |-> !push && !pix.ready)
		else $error("pipe advanced into a full result queue");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_s7) && $stable(hit_s7))
		else $error("table stage moved during a stall");

	a_stall_data: assert property (@(posedge clk) disable iff (!arst_n)
		!adv && vld_s7 && hit_s7 |=> $stable(rd_data))
		else $error("table read data moved during a stall");

	a_transfer_enters: assert property (@(posedge clk) disable iff (!arst_n)
		pix.valid && pix.ready |=> vld_s1)
		else $error("transferred item missing from first stage");

endmodule

/* bench/circular_band_shade_lut_core_tb.sv */
// Self-checking bench for the ring shader core: table loads, ring shading, stalls and back-pressure.
module circular_band_shade_lut_core_tb;
	import cbs_pkg::*;

	localparam int MAX_BAND     = 16;
	localparam int TABLE_DEPTH  = 4096;
	localparam int SETTLE       = 40;
	localparam int HOLD_CYCLES  = 400;
	localparam int CYCLE_LIMIT  = 500000;
	localparam int RAND_PHASES  = 8;
	localparam int ITEM_TARGET  = 1950;

	typedef enum {RX_FREE, RX_RANDOM, RX_PATTERN} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n;

	cbs_pix_if pix();
	cbs_res_if res();
	cbs_cfg_if cfg();

	circular_band_shade_lut_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pix    (pix),
		.res    (res),
		.cfg    (cfg)
	);

	always #10 clk = ~clk;

	// shadow of the block's registers and table
	logic [COORD_W-1:0]  ring_col;
	logic [COORD_W-1:0]  ring_row;
	logic [RADIUS_W-1:0] ring_rad;
	logic [BAND_W-1:0]   ring_band;
	logic [VAL_W-1:0]    lut_copy [TABLE_DEPTH];
	bit                  lut_written [TABLE_DEPTH];

	res_t     expected_shades [$];
	rx_mode_t rx_mode = RX_FREE;
	bit       gaps_on = 1'b0;
	int       burst_left = 0;
	int       hold_req = 0;
	int       hold_ack = 0;
	int       hold_left = 0;
	logic [15:0] stall_pat = 16'b1011_0111_1101_1110;

	int n_items = 0;
	int n_loads = 0;
	int n_results = 0;
	int n_shaded = 0;
	int n_settings = 0;
	int n_errors = 0;
	int cycles = 0;

	function automatic int unsigned isqrt(input int unsigned x);
		int unsigned r;
		int unsigned trial;
		r = 0;
		for (int b = 15; b >= 0; b--) begin
			trial = r | (32'd1 << b);
			if (trial * trial <= x)
				r = trial;
		end
		return r;
	endfunction

	function automatic int eff_band();
		return (ring_band > MAX_BAND) ? MAX_BAND : int'(ring_band);
	endfunction

	// table address a pixel reads, if it falls in the ring
	function automatic bit ring_lookup(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row,
		input logic [VAL_W-1:0] v, output int unsigned addr);
		int unsigned dc;
		int unsigned dr;
		int unsigned d;
		int unsigned band;
		dc = (col >= ring_col) ? 32'(col - ring_col) : 32'(ring_col - col);
		dr = (row >= ring_row) ? 32'(row - ring_row) : 32'(ring_row - row);
		d = isqrt(dc * dc + dr * dr);
		band = eff_band();
		addr = 0;
		if (band == 0 || d >= ring_rad || d + band < ring_rad)
			return 1'b0;
		addr = v * band + d + band - ring_rad;
		return addr < TABLE_DEPTH;
	endfunction

	// a pixel whose distance from the centre lies close to the ring
	function automatic void near_ring(output logic [COORD_W-1:0] col, output logic [COORD_W-1:0] row);
		int t;
		int dc;
		int dr;
		int sw;
		int c;
		int r;
		t = int'(ring_rad) - eff_band() - 1 + int'($urandom_range(0, eff_band() + 2));
		if (t < 0)
			t = 0;
		dc = $urandom_range(0, t);
		dr = isqrt(t * t - dc * dc);
		if ($urandom_range(0, 1)) begin
			sw = dc;
			dc = dr;
			dr = sw;
		end
		c = $urandom_range(0, 1) ? int'(ring_col) + dc : int'(ring_col) - dc;
		r = $urandom_range(0, 1) ? int'(ring_row) + dr : int'(ring_row) - dr;
		if (c < 0 || c > 2047)
			c = 2 * int'(ring_col) - c;
		if (r < 0 || r > 2047)
			r = 2 * int'(ring_row) - r;
		col = COORD_W'((c < 0) ? 0 : (c > 2047) ? 2047 : c);
		row = COORD_W'((r < 0) ? 0 : (r > 2047) ? 2047 : r);
	endfunction

	task automatic send_item(input action_t act, input logic [COORD_W-1:0] col,
		input logic [COORD_W-1:0] row, input logic [VAL_W-1:0] v,
		input logic [TIDX_W-1:0] tidx, input logic [VAL_W-1:0] tdat);
		int gap;
		int unsigned addr;
		res_t e;
		if (gaps_on) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 40);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				if (gap > 0) begin
					pix.valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			burst_left--;
		end
		pix.valid       <= 1'b1;
		pix.action      <= act;
		pix.pixel_col   <= col;
		pix.pixel_row   <= row;
		pix.pixel_value <= v;
		pix.table_index <= tidx;
		pix.table_data  <= tdat;
		do @(posedge clk); while (!pix.ready);
		n_items++;
		if (act == ACT_LOAD) begin
			lut_copy[tidx] = tdat;
			lut_written[tidx] = 1'b1;
			n_loads++;
		end else begin
			if (ring_lookup(col, row, v, addr)) begin
				e.value = lut_copy[addr[TIDX_W-1:0]];
				e.in_band = 1'b1;
			end else begin
				e.value = v;
				e.in_band = 1'b0;
			end
			expected_shades.push_back(e);
		end
	endtask

	task automatic send_load(input logic [TIDX_W-1:0] tidx, input logic [VAL_W-1:0] tdat);
		send_item(ACT_LOAD, COORD_W'($urandom), COORD_W'($urandom), VAL_W'($urandom), tidx, tdat);
	endtask

	// a pixel that would read an unloaded entry gets that entry loaded first
	task automatic send_pixel(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row,
		input logic [VAL_W-1:0] v);
		int unsigned addr;
		if (ring_lookup(col, row, v, addr) && !lut_written[addr[TIDX_W-1:0]])
			send_load(addr[TIDX_W-1:0], VAL_W'($urandom));
		send_item(ACT_SHADE, col, row, v, TIDX_W'($urandom), VAL_W'($urandom));
	endtask

	task automatic wait_idle();
		pix.valid <= 1'b0;
		burst_left = 0;
		while (expected_shades.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= data;
		do @(posedge clk); while (!cfg.ready);
		case (idx)
			CFG_CENTER_COL: ring_col = data[COORD_W-1:0];
			CFG_CENTER_ROW: ring_row = data[COORD_W-1:0];
			CFG_RADIUS:     ring_rad = data[RADIUS_W-1:0];
			CFG_BAND_WIDTH: ring_band = data[BAND_W-1:0];
			default: ;
		endcase
	endtask

	// unused upper data bits carry junk, which the block must drop
	task automatic set_ring(input int col, input int row, input int rad, input int band);
		logic [CFG_DATA_W-1:0] d;
		d = CFG_DATA_W'($urandom);
		d[COORD_W-1:0] = COORD_W'(col);
		write_reg(CFG_CENTER_COL, d);
		d = CFG_DATA_W'($urandom);
		d[COORD_W-1:0] = COORD_W'(row);
		write_reg(CFG_CENTER_ROW, d);
		write_reg(CFG_RADIUS, CFG_DATA_W'(rad));
		d = CFG_DATA_W'($urandom);
		d[BAND_W-1:0] = BAND_W'(band);
		write_reg(CFG_BAND_WIDTH, d);
		cfg.valid <= 1'b0;
		@(posedge clk);
		n_settings++;
	endtask

	// reset values: centre at the origin, radius 64, band 16
	task automatic test_reset_defaults();
		rx_mode = RX_FREE;
		gaps_on = 1'b0;
		send_item(ACT_LOAD, 11'd2047, 11'd2047, 8'd255, 12'd0, 8'hA5);
		send_item(ACT_LOAD, 11'd0, 11'd0, 8'd0, 12'd4095, 8'd255);
		send_item(ACT_LOAD, 11'd2047, 11'd0, 8'd255, 12'h555, 8'd0);
		send_pixel(11'd0, 11'd0, 8'd0);
		send_pixel(11'd63, 11'd0, 8'd255);
		send_pixel(11'd0, 11'd48, 8'd0);
		send_pixel(11'd64, 11'd0, 8'd7);
		send_pixel(11'd47, 11'd0, 8'd7);
		send_pixel(11'd45, 11'd45, 8'd200);
		send_pixel(11'd2047, 11'd2047, 8'd128);
		wait_idle();
	endtask

	// zero band, band above the maximum and wider than the radius, smallest ring
	task automatic test_band_limits();
		rx_mode = RX_PATTERN;
		set_ring(1024, 1024, 10, 0);
		send_pixel(11'd1033, 11'd1024, 8'd9);
		send_pixel(11'd1024, 11'd1024, 8'd1);
		send_pixel(11'd1030, 11'd1030, 8'd255);
		wait_idle();
		set_ring(1024, 1024, 10, 31);
		send_pixel(11'd1024, 11'd1024, 8'd3);
		send_pixel(11'd1024, 11'd1033, 8'd255);
		send_pixel(11'd1034, 11'd1024, 8'd0);
		wait_idle();
		set_ring(1024, 1024, 1, 1);
		send_pixel(11'd1024, 11'd1024, 8'd255);
		send_pixel(11'd1025, 11'd1024, 8'd5);
		wait_idle();
	endtask

	// largest distances, largest radius, radius zero
	task automatic test_far_corners();
		rx_mode = RX_RANDOM;
		set_ring(0, 0, 2896, 16);
		send_pixel(11'd2047, 11'd2047, 8'd255);
		send_pixel(11'd0, 11'd0, 8'd0);
		wait_idle();
		set_ring(2047, 2047, 2896, 16);
		send_pixel(11'd0, 11'd0, 8'd1);
		wait_idle();
		set_ring(0, 2047, 4095, 31);
		send_pixel(11'd2047, 11'd0, 8'd9);
		wait_idle();
		set_ring(0, 0, 0, 16);
		send_pixel(11'd0, 11'd0, 8'd0);
		send_pixel(11'd1, 11'd0, 8'd77);
		wait_idle();
	endtask

	// output held off while input keeps coming, so the core fills and stalls its input
	task automatic test_backpressure();
		logic [COORD_W-1:0] c;
		logic [COORD_W-1:0] r;
		rx_mode = RX_FREE;
		gaps_on = 1'b0;
		set_ring(1000, 1000, 40, 8);
		hold_req++;
		repeat (150) begin
			near_ring(c, r);
			send_pixel(c, r, VAL_W'($urandom));
		end
		wait_idle();
	endtask

	task automatic test_random_traffic();
		logic [COORD_W-1:0] c;
		logic [COORD_W-1:0] r;
		int rad;
		int band;
		int pick;
		int phase_end;
		gaps_on = 1'b1;
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			rx_mode = rx_mode_t'(ph % 3);
			rad = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2896) : $urandom_range(1, 200);
			band = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 16);
			set_ring($urandom_range(0, 2047), $urandom_range(0, 2047), rad, band);
			phase_end = n_items + (ITEM_TARGET - n_items) / (RAND_PHASES - ph);
			while (n_items < phase_end) begin
				pick = $urandom_range(0, 9);
				if (pick == 0) begin
					send_load(TIDX_W'($urandom), VAL_W'($urandom));
				end else if (pick <= 2) begin
					send_pixel(COORD_W'($urandom), COORD_W'($urandom), VAL_W'($urandom));
				end else begin
					near_ring(c, r);
					send_pixel(c, r, VAL_W'($urandom));
				end
			end
			wait_idle();
		end
		gaps_on = 1'b0;
	endtask

	always @(posedge clk) begin
		if (hold_ack != hold_req) begin
			hold_ack <= hold_req;
			hold_left <= HOLD_CYCLES;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// result checker and receiver stalls
	always @(posedge clk) begin
		res_t e;
		if (arst_n && res.valid && res.ready) begin
			n_results++;
			if (expected_shades.size() == 0) begin
				$error("unexpected result: out_value %0d in_band %0b", res.out_value, res.in_band);
				n_errors++;
			end else begin
				e = expected_shades.pop_front();
				if (res.out_value !== e.value) begin
					$error("out_value: expected %0d, got %0d", e.value, res.out_value);
					n_errors++;
				end
				if (res.in_band !== e.in_band) begin
					$error("in_band: expected %0b, got %0b", e.in_band, res.in_band);
					n_errors++;
				end
				if (e.in_band)
					n_shaded++;
			end
		end
		stall_pat <= {stall_pat[0], stall_pat[15:1]};
		if (!arst_n || hold_left > 0)
			res.ready <= 1'b0;
		else case (rx_mode)
			RX_RANDOM:  res.ready <= ($urandom_range(0, 3) != 0);
			RX_PATTERN: res.ready <= stall_pat[0];
			default:    res.ready <= 1'b1;
		endcase
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		arst_n          <= 1'b0;
		pix.valid       <= 1'b0;
		pix.action      <= ACT_LOAD;
		pix.pixel_col   <= '0;
		pix.pixel_row   <= '0;
		pix.pixel_value <= '0;
		pix.table_index <= '0;
		pix.table_data  <= '0;
		cfg.valid       <= 1'b0;
		cfg.index       <= CFG_CENTER_COL;
		cfg.data        <= '0;
		ring_col  = '0;
		ring_row  = '0;
		ring_rad  = RADIUS_RST;
		ring_band = BAND_RST;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_band_limits();
		test_far_corners();
		test_backpressure();
		test_random_traffic();

		$display("tb: %0d items in (%0d table loads), %0d pixel results checked, %0d shaded",
			n_items, n_loads, n_results, n_shaded);
		$display("tb: %0d ring settings, %0d mismatches", n_settings, n_errors);
		if (n_errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

/* sim.f */
rtl/core/cbs_pkg.sv
rtl/core/cbs_ifs.sv
rtl/core/cbs_shade_mem.sv
rtl/core/circular_band_shade_lut_core.sv
bench/circular_band_shade_lut_core_tb.sv
